FILE: rtl/gbr_pkg.sv
// Package for the Gaussian Bayes ratio argmax core.
// Holds sizes, fixed-point constants and the model entry type; no dependencies.
package gbr_pkg;

    localparam int FEATURES    = 64;
    localparam int MAX_SAMPLES = 4096;
    localparam int FEAT_W      = $clog2(FEATURES);
    localparam int NUM_W       = 12;
    localparam int SUM_W       = 40;

    localparam logic signed [33:0] LN_FLOOR = -34'sd4527066;
    localparam logic [31:0]        LN2_Q32  = 32'd2977044472;
    localparam logic [30:0]        Q_CAP    = 31'h7FFF_FFFF;
    localparam logic [NUM_W-1:0]   CNT_MAX  = NUM_W'(MAX_SAMPLES - 1);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SCORE = 1'b1;

    typedef struct packed {
        logic signed [31:0] mean;
        logic [31:0]        inv;
        logic signed [31:0] lns;
    } t_entry;

endpackage

FILE: rtl/gbr_if.sv
// Channel interfaces for the Gaussian Bayes ratio argmax core.
// Input item channel and result item channel; no dependencies.
interface gbr_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [5:0]         feature_index;
    logic               class_select;
    logic signed [31:0] value;
    logic [31:0]        spread;
    logic               last_feature;
    logic               last_sample;

    modport source (output valid, cmd, feature_index, class_select, value, spread,
                    last_feature, last_sample, input ready);
    modport sink (input valid, cmd, feature_index, class_select, value, spread,
                  last_feature, last_sample, output ready);
endinterface

interface gbr_out_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] sample_score;
    logic [11:0]        sample_number;
    logic signed [39:0] best_score;
    logic [11:0]        best_number;
    logic               batch_done;

    modport source (output valid, sample_score, sample_number, best_score,
                    best_number, batch_done, input ready);
    modport sink (input valid, sample_score, sample_number, best_score,
                  best_number, batch_done, output ready);
endinterface

FILE: rtl/gbr_recip.sv
// Serial reciprocal unit: floor(2^47 / S^2), saturated to 32 bits.
// Squares once, then one restoring division step per cycle. Uses gbr_pkg.
module gbr_recip
    import gbr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_spread,
    output logic        o_done,
    output logic [31:0] o_inv
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_CHK  = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0]  r_state;
    logic        r_done;
    logic [31:0] r_s;
    logic [63:0] r_sq;
    logic [63:0] r_rem;
    logic [31:0] r_q;
    logic [5:0]  r_cnt;
    logic [64:0] n_trial;

    assign n_trial = {r_rem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_s     <= i_spread;
                        r_done  <= 1'b0;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_sq    <= 64'(r_s) * 64'(r_s);
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    // A square of 2^15 or less would give a quotient above 32 bits.
                    if (r_sq <= 64'd32768) begin
                        r_q     <= 32'hFFFF_FFFF;
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_rem   <= 64'd32768;
                        r_q     <= '0;
                        r_cnt   <= 6'd32;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (n_trial >= {1'b0, r_sq}) begin
                        r_rem <= 64'(n_trial - {1'b0, r_sq});
                        r_q   <= {r_q[30:0], 1'b1};
                    end else begin
                        r_rem <= n_trial[63:0];
                        r_q   <= {r_q[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_inv  = r_q;

endmodule

FILE: rtl/gbr_log.sv
// Serial natural logarithm unit for a Q16.16 spread.
// Sixteen mantissa squarings, one per cycle, then a scale by ln 2. Uses gbr_pkg.
module gbr_log
    import gbr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_spread,
    output logic               o_done,
    output logic signed [31:0] o_lns
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NORM = 3'd1;
    localparam logic [2:0] ST_SQR  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_RND  = 3'd4;

    logic [2:0]         r_state;
    logic               r_done;
    logic [31:0]        r_s;
    logic [31:0]        r_m;
    logic [4:0]         r_p;
    logic [15:0]        r_frac;
    logic [4:0]         r_cnt;
    logic               r_neg;
    logic [52:0]        r_prod;
    logic signed [31:0] r_lns;

    logic [4:0]         n_msb;
    logic [63:0]        n_sq;
    logic [32:0]        n_msq;
    logic signed [21:0] n_l;
    logic [20:0]        n_mag;
    logic [52:0]        n_rnd;

    always_comb begin
        n_msb = '0;
        for (int i = 0; i < 32; i++) begin
            if (r_s[i]) n_msb = 5'(i);
        end
    end

    assign n_sq  = 64'(r_m) * 64'(r_m);
    assign n_msq = n_sq[63:31];
    assign n_l   = ($signed({17'b0, r_p}) - 22'sd16) * 22'sd65536
                   + $signed({6'b0, r_frac});
    assign n_mag = n_l[21] ? 21'(-n_l) : n_l[20:0];
    assign n_rnd = r_prod + 53'(64'h8000_0000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_s     <= i_spread;
                        r_done  <= 1'b0;
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if (r_s == '0) begin
                        r_lns   <= 32'(LN_FLOOR);
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_p     <= n_msb;
                        r_m     <= r_s << (5'd31 - n_msb);
                        r_frac  <= '0;
                        r_cnt   <= 5'd16;
                        r_state <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    if (n_msq[32]) begin
                        r_m    <= n_msq[32:1];
                        r_frac <= {r_frac[14:0], 1'b1};
                    end else begin
                        r_m    <= n_msq[31:0];
                        r_frac <= {r_frac[14:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_neg   <= n_l[21];
                    r_prod  <= 53'(n_mag) * 53'(LN2_Q32);
                    r_state <= ST_RND;
                end
                ST_RND: begin
                    r_lns   <= r_neg ? -$signed({11'b0, n_rnd[52:32]})
                                     : $signed({11'b0, n_rnd[52:32]});
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_lns  = r_lns;

endmodule

FILE: rtl/gaussian_bayes_ratio_argmax_core.sv
// Top level of the Gaussian Bayes ratio argmax core: model memories,
// score datapath and argmax. Uses gbr_pkg, gbr_if, gbr_recip and gbr_log.
//
//   channel   direction  contents
//   i_in      sink       load or score item
//   o_out     source     one result item per finished sample
//
// A score item runs through memory read, difference, square, scale, floor and
// accumulate, in that order. A load item lasts until both the serial reciprocal
// divider and the logarithm unit running beside it are done; the divider ends
// last unless it saturates on a nonzero spread, when the logarithm unit does.
// Items are taken one at a time; a held result stalls only a sample's last accumulate.
// Synchronous active-low reset clears control state; memories need no clearing.
module gaussian_bayes_ratio_argmax_core
    import gbr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    gbr_in_if.sink    i_in,
    gbr_out_if.source o_out
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_SQ   = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_TERM = 3'd5;
    localparam logic [2:0] ST_ACC  = 3'd6;

    logic [2:0]              r_state;
    logic                    r_cls;
    logic [FEAT_W-1:0]       r_addr;
    logic signed [31:0]      r_x;
    logic                    r_last_f;
    logic                    r_last_s;

    t_entry                  r_mem_pos [0:FEATURES-1];
    t_entry                  r_mem_neg [0:FEATURES-1];
    t_entry                  r_rd_pos;
    t_entry                  r_rd_neg;

    logic [32:0]             r_ad_pos, r_ad_neg;
    logic [65:0]             r_d2_pos, r_d2_neg;
    logic [65:0]             r_hi_pos, r_hi_neg;
    logic [31:0]             r_lo_pos, r_lo_neg;
    logic signed [33:0]      r_t_pos, r_t_neg;

    logic signed [SUM_W-1:0] r_sum;
    logic [NUM_W-1:0]        r_count;
    logic signed [SUM_W-1:0] r_best;
    logic [NUM_W-1:0]        r_best_pos;

    logic                    r_out_valid;
    logic signed [SUM_W-1:0] r_out_score;
    logic [NUM_W-1:0]        r_out_num;
    logic signed [SUM_W-1:0] r_out_best;
    logic [NUM_W-1:0]        r_out_best_num;
    logic                    r_out_done;

    logic                    n_accept;
    logic                    n_start;
    logic                    n_inv_done, n_log_done;
    logic [31:0]             n_inv;
    logic signed [31:0]      n_lns;
    logic signed [32:0]      n_d_pos, n_d_neg;
    logic signed [41:0]      n_s42;
    logic signed [SUM_W-1:0] n_s;
    logic                    n_out_free;

    function automatic logic signed [33:0] term_of(input logic [65:0] hi,
                                                   input logic [31:0] lo,
                                                   input logic signed [31:0] lns);
        logic [32:0]        sum;
        logic [30:0]        q;
        logic signed [33:0] t;
        sum = 33'(hi[31:0]) + 33'(lo);
        if (hi > 66'(Q_CAP) || sum > 33'(Q_CAP)) q = Q_CAP;
        else q = sum[30:0];
        t = -$signed({3'b0, q}) - 34'(lns);
        if (t < LN_FLOOR) t = LN_FLOOR;
        return t;
    endfunction

    assign i_in.ready = (r_state == ST_IDLE);
    assign n_accept   = i_in.valid && i_in.ready;
    assign n_start    = n_accept && (i_in.cmd == CMD_LOAD);
    assign n_out_free = !r_out_valid || o_out.ready;

    gbr_recip u_recip (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (n_start),
        .i_spread (i_in.spread),
        .o_done   (n_inv_done),
        .o_inv    (n_inv)
    );

    gbr_log u_log (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (n_start),
        .i_spread (i_in.spread),
        .o_done   (n_log_done),
        .o_lns    (n_lns)
    );

    // Both class entries of a feature are read together from two memories.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD && n_inv_done && n_log_done) begin
            if (r_cls) r_mem_neg[r_addr] <= '{mean: r_x, inv: n_inv, lns: n_lns};
            else       r_mem_pos[r_addr] <= '{mean: r_x, inv: n_inv, lns: n_lns};
        end
        if (n_accept && i_in.cmd == CMD_SCORE) begin
            r_rd_pos <= r_mem_pos[FEAT_W'(i_in.feature_index % FEATURES)];
            r_rd_neg <= r_mem_neg[FEAT_W'(i_in.feature_index % FEATURES)];
        end
    end

    assign n_d_pos = $signed({r_x[31], r_x}) - $signed({r_rd_pos.mean[31], r_rd_pos.mean});
    assign n_d_neg = $signed({r_x[31], r_x}) - $signed({r_rd_neg.mean[31], r_rd_neg.mean});

    always_comb begin
        n_s42 = 42'(r_sum) + 42'(r_t_pos) - 42'(r_t_neg);
        if (n_s42 > 42'(SUM_MAX))      n_s = SUM_MAX;
        else if (n_s42 < 42'(SUM_MIN)) n_s = SUM_MIN;
        else                           n_s = n_s42[SUM_W-1:0];
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_cls    <= i_in.class_select;
            r_addr   <= FEAT_W'(i_in.feature_index % FEATURES);
            r_x      <= i_in.value;
            r_last_f <= i_in.last_feature;
            r_last_s <= i_in.last_sample;
        end
        if (r_state == ST_RD) begin
            r_ad_pos <= n_d_pos[32] ? 33'(-n_d_pos) : n_d_pos[32:0];
            r_ad_neg <= n_d_neg[32] ? 33'(-n_d_neg) : n_d_neg[32:0];
        end
        if (r_state == ST_SQ) begin
            r_d2_pos <= 66'(r_ad_pos) * 66'(r_ad_pos);
            r_d2_neg <= 66'(r_ad_neg) * 66'(r_ad_neg);
        end
        if (r_state == ST_MUL) begin
            r_hi_pos <= 66'(r_d2_pos[65:32]) * 66'(r_rd_pos.inv);
            r_hi_neg <= 66'(r_d2_neg[65:32]) * 66'(r_rd_neg.inv);
            r_lo_pos <= 32'((64'(r_d2_pos[31:0]) * 64'(r_rd_pos.inv)) >> 32);
            r_lo_neg <= 32'((64'(r_d2_neg[31:0]) * 64'(r_rd_neg.inv)) >> 32);
        end
        if (r_state == ST_TERM) begin
            r_t_pos <= term_of(r_hi_pos, r_lo_pos, r_rd_pos.lns);
            r_t_neg <= term_of(r_hi_neg, r_lo_neg, r_rd_neg.lns);
        end
    end

    // Control, accumulator, argmax and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_count     <= '0;
            r_best      <= SUM_MIN;
            r_best_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A result leaving while the next one is loaded keeps valid high.
            if (r_out_valid && o_out.ready && !(r_state == ST_ACC && r_last_f))
                r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (n_accept) r_state <= (i_in.cmd == CMD_LOAD) ? ST_LOAD : ST_RD;
                end
                ST_LOAD: begin
                    if (n_inv_done && n_log_done) r_state <= ST_IDLE;
                end
                ST_RD:   r_state <= ST_SQ;
                ST_SQ:   r_state <= ST_MUL;
                ST_MUL:  r_state <= ST_TERM;
                ST_TERM: r_state <= ST_ACC;
                ST_ACC: begin
                    if (!r_last_f) begin
                        r_sum   <= n_s;
                        r_state <= ST_IDLE;
                    end else if (n_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_score <= n_s;
                        r_out_num   <= r_count;
                        r_out_done  <= r_last_s;
                        if (n_s > r_best) begin
                            r_out_best     <= n_s;
                            r_out_best_num <= r_count;
                        end else begin
                            r_out_best     <= r_best;
                            r_out_best_num <= r_best_pos;
                        end
                        r_sum <= '0;
                        if (r_last_s) begin
                            r_count    <= '0;
                            r_best     <= SUM_MIN;
                            r_best_pos <= '0;
                        end else begin
                            if (n_s > r_best) begin
                                r_best     <= n_s;
                                r_best_pos <= r_count;
                            end
                            if (r_count < CNT_MAX) r_count <= r_count + 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.sample_score  = r_out_score;
    assign o_out.sample_number = r_out_num;
    assign o_out.best_score    = r_out_best;
    assign o_out.best_number   = r_out_best_num;
    assign o_out.batch_done    = r_out_done;

endmodule
